>>> src/sgbp_pkg.sv
// ----------------------------------------------------------------------------
// Symbol group bit packer package
// Shared transaction payload types and the stage-to-stage control structs.
// ----------------------------------------------------------------------------
package sgbp_pkg;

  localparam int unsigned GroupBytes = 8;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned WordBits   = GroupBytes * ByteBits;
  localparam int unsigned MinBits    = 2;

  // Input transaction: one spatial group and one temporal group.
  typedef struct packed {
    logic [WordBits-1:0] spatial_residual;
    logic [WordBits-1:0] temporal_residual;
  } in_t;

  // Output transaction: mode, packed fields and their byte count.
  typedef struct packed {
    logic [3:0]          mode_code;
    logic [WordBits-1:0] packed_word;
    logic [3:0]          packed_bytes;
  } out_t;

  // Magnitude summary of one group after sign folding.
  typedef struct packed {
    logic       zero;
    logic [6:0] acc;
  } fold_t;

  // Chosen group and its width in bits.
  typedef struct packed {
    logic [3:0] k;
    logic       temporal;
  } sel_t;

endpackage

>>> src/sgbp_fold.sv
// ----------------------------------------------------------------------------
// Group sign fold
// Folds each signed byte to its magnitude bits and ORs them over the group.
// ----------------------------------------------------------------------------
module sgbp_fold import sgbp_pkg::*; (
  input  logic [WordBits-1:0] group_i,
  output fold_t               fold_o
);

  logic [6:0] acc;

  // A negative byte is inverted so that its top set bit gives the width.
  always_comb begin
    acc = 7'h01;
    for (int i = 0; i < GroupBytes; i++) begin
      acc = acc | (group_i[i*ByteBits +: 7] ^ {7{group_i[i*ByteBits + 7]}});
    end
  end

  assign fold_o.zero = (group_i == '0);
  assign fold_o.acc  = acc;

endmodule

>>> src/sgbp_select.sv
// ----------------------------------------------------------------------------
// Group width select
// Turns both folded summaries into widths and picks the group to pack.
// ----------------------------------------------------------------------------
module sgbp_select import sgbp_pkg::*; (
  input  fold_t spatial_i,
  input  fold_t temporal_i,
  input  logic  delta_mode_i,
  output sel_t  sel_o
);

  function automatic logic [3:0] width_of(fold_t f);
    logic [2:0] m;
    m = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (f.acc[i]) begin
        m = 3'(i);
      end
    end
    return f.zero ? 4'd0 : ({1'b0, m} + 4'(MinBits));
  endfunction

  logic [3:0] k_s;
  logic [3:0] k_t;
  logic       use_t;

  assign k_s   = width_of(spatial_i);
  assign k_t   = width_of(temporal_i);
  // The temporal group wins a tie.
  assign use_t = delta_mode_i && (k_t <= k_s);

  assign sel_o.k        = use_t ? k_t : k_s;
  assign sel_o.temporal = use_t;

endmodule

>>> src/sgbp_pack.sv
// ----------------------------------------------------------------------------
// Field packer
// Biases each byte by half its range and packs the k-bit fields into a word.
// ----------------------------------------------------------------------------
module sgbp_pack import sgbp_pkg::*; (
  input  logic [WordBits-1:0] group_i,
  input  logic [3:0]          k_i,
  output logic [WordBits-1:0] word_o
);

  logic [WordBits-1:0] cand [MinBits:ByteBits];
  logic [ByteBits-1:0] field;

  // One candidate word per legal width; the shifts are fixed in each.
  always_comb begin
    field = '0;
    for (int kk = MinBits; kk <= ByteBits; kk++) begin
      cand[kk] = '0;
      for (int i = 0; i < GroupBytes; i++) begin
        field = (group_i[i*ByteBits +: ByteBits] ^ ByteBits'(1 << (kk - 1)))
                & ByteBits'((1 << kk) - 1);
        cand[kk] = cand[kk] | (WordBits'(field) << (i * kk));
      end
    end
  end

  always_comb begin
    word_o = '0;
    for (int kk = MinBits; kk <= ByteBits; kk++) begin
      if (k_i == 4'(kk)) begin
        word_o = cand[kk];
      end
    end
  end

endmodule

>>> src/symbol_group_bit_packer.sv
// ----------------------------------------------------------------------------
// Symbol group bit packer
// Sizes groups of eight signed residual bytes and packs them into k bytes.
// ----------------------------------------------------------------------------
// Usage: an input transaction carries a spatial and a temporal residual group
// of eight signed bytes each on in_data_i, under valid/ready. Each accepted
// transaction yields exactly one output transaction on out_data_o: the mode
// code, the packed word and its byte count, in the order of the inputs.
// The delta_mode register is written through cfg_we_i/cfg_wdata_i and should
// only change while no transaction is in flight; it resets to spatial only.
// The work is a fold stage, a width select stage and a pack stage, each ending
// in a register; the first register loads at the accepting edge, and
// out_valid_o rises once the transaction has moved on through the select and
// pack stage registers. The block takes one transaction per cycle
// as long as the receiver keeps out_ready_i high. When the receiver stalls,
// the output register holds its transaction and the stages behind it keep
// filling until every stage is occupied; only then does in_ready_o drop.
// Nothing is lost or repeated across a stall.
// Reset clears all stage valid bits and the delta_mode register at once.
// ----------------------------------------------------------------------------
module symbol_group_bit_packer import sgbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // Configuration register.
  logic delta_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      delta_mode_q <= cfg_wdata_i;
    end
  end

  // Stage valid bits and the enables that let each stage take new data.
  // A stage loads when it is empty or when its contents move on.
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage 1: fold both groups into magnitude summaries.
  fold_t fold_s_d, fold_t_d;
  fold_t fold_s_q, fold_t_q;
  in_t   grp1_q;

  sgbp_fold u_fold_s (
    .group_i (in_data_i.spatial_residual),
    .fold_o  (fold_s_d)
  );

  sgbp_fold u_fold_t (
    .group_i (in_data_i.temporal_residual),
    .fold_o  (fold_t_d)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      fold_s_q <= fold_s_d;
      fold_t_q <= fold_t_d;
      grp1_q   <= in_data_i;
    end
  end

  // Stage 2: derive widths, choose the group to pack and keep only it.
  sel_t                sel_d;
  sel_t                sel_q;
  logic [WordBits-1:0] grp2_d;
  logic [WordBits-1:0] grp2_q;

  sgbp_select u_select (
    .spatial_i    (fold_s_q),
    .temporal_i   (fold_t_q),
    .delta_mode_i (delta_mode_q),
    .sel_o        (sel_d)
  );

  assign grp2_d = sel_d.temporal ? grp1_q.temporal_residual : grp1_q.spatial_residual;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sel_q  <= sel_d;
      grp2_q <= grp2_d;
    end
  end

  // Stage 3: bias and pack the fields, then form the mode code.
  logic [WordBits-1:0] word_d;
  out_t                out_d;
  out_t                out_q;

  sgbp_pack u_pack (
    .group_i (grp2_q),
    .k_i     (sel_q.k),
    .word_o  (word_d)
  );

  always_comb begin
    out_d.mode_code       = (sel_q.k == 4'd0) ? 4'd0 : (sel_q.k - 4'd1);
    out_d.mode_code[3]    = sel_q.temporal;
    out_d.packed_word     = word_d;
    out_d.packed_bytes    = sel_q.k;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // The byte count always agrees with the width in the mode code.
  a_bytes_match_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.packed_bytes == 4'd0 && out_data_o.mode_code[2:0] == 3'd0)
      || (out_data_o.packed_bytes == ({1'b0, out_data_o.mode_code[2:0]} + 4'd1))))
    else $error("packed_bytes disagrees with mode_code");

  // A width of one bit never occurs and widths never exceed a byte.
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.packed_bytes != 4'd1 && out_data_o.packed_bytes <= 4'd8))
    else $error("packed_bytes out of range");

  // A zero group packs to an all-zero word.
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.packed_bytes == 4'd0) |-> (out_data_o.packed_word == '0))
    else $error("zero group produced a nonzero word");

  // Without delta mode the temporal group is never chosen.
  a_spatial_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !delta_mode_q) |-> !out_data_o.mode_code[3])
    else $error("temporal group chosen outside delta mode");
`endif

endmodule
